// ===== sv/scoped_symbol_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scoped symbol table core
// Concurrent checks clocked on clk_i, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_TABLE_CORE_ASSERT_SVH
`define SCOPED_SYMBOL_TABLE_CORE_ASSERT_SVH

// Check while out of reset.
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared widths, codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 32;
  localparam int LVL_W = 8;
  localparam int CMD_W = 2;
  localparam int ST_W  = 3;

  localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SCOPE  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_TOO_DEEP  = 3'd4;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLOSE  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [LVL_W-1:0] level;
    logic             hit;
    logic [LVL_W-1:0] best_level;
    logic [VAL_W-1:0] best_value;
  } token_t;

endpackage

// ===== sv/sst_cell.sv =====
// ----------------------------------------------------------------------------
// sst_cell
// One table slot: valid, key, value and owning level; acts on the passing
// token and hands it on to the next cell through a register, in the next cycle.
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  sst_pkg::token_t tok_i,
  output logic            tok_valid_o,
  output sst_pkg::token_t tok_o
);

  logic                        valid_q;
  logic [sst_pkg::KEY_W-1:0]   key_q;
  logic [sst_pkg::VAL_W-1:0]   value_q;
  logic [sst_pkg::LVL_W-1:0]   level_q;
  logic                        tok_valid_q;
  sst_pkg::token_t             tok_q;
  sst_pkg::token_t             tok_d;
  logic                        key_eq;
  logic                        lvl_eq;
  logic                        do_update;
  logic                        do_insert;
  logic                        do_drop;

  assign key_eq = (key_q == tok_i.key);
  assign lvl_eq = (level_q == tok_i.level);

  assign do_update = tok_valid_i && (tok_i.op == sst_pkg::OP_FIND) && valid_q && key_eq && lvl_eq;
  assign do_insert = tok_valid_i && (tok_i.op == sst_pkg::OP_INSERT) && !valid_q && !tok_i.hit;
  assign do_drop   = tok_valid_i && (tok_i.op == sst_pkg::OP_CLOSE) && valid_q && lvl_eq;

  always_comb begin
    tok_d = tok_i;
    case (tok_i.op)
      sst_pkg::OP_FIND: begin
        if (valid_q && key_eq && lvl_eq) tok_d.hit = 1'b1;
      end
      sst_pkg::OP_INSERT: begin
        if (!valid_q) tok_d.hit = 1'b1;
      end
      sst_pkg::OP_LOOKUP: begin
        if (valid_q && key_eq && (level_q > tok_i.best_level)) begin
          tok_d.hit        = 1'b1;
          tok_d.best_level = level_q;
          tok_d.best_value = value_q;
        end
      end
      default: begin
        tok_d = tok_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
      if (do_insert) begin
        valid_q <= 1'b1;
      end else if (do_drop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (do_insert) begin
      key_q   <= tok_i.key;
      value_q <= tok_i.value;
      level_q <= tok_i.level;
    end else if (do_update) begin
      value_q <= tok_i.value;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== sv/scoped_symbol_table_core.sv =====
// ----------------------------------------------------------------------------
// scoped_symbol_table_core
// Nested-scope symbol table built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word per command (open, assign, lookup, close)
// with a 64-bit key and a 32-bit value. Output stream m_axis: one word per
// command with a status code and the value found by a lookup.
// Open, and any command given with no scope open, finish at once: the
// result passes through the S_DONE state into the output register. Assign,
// lookup and close send a token down the row of MAX_ENTRIES cells, cell by
// cell: lookup, close and an assign that updates walk the row once; an
// assign that inserts walks it twice. The row length sets the rate.
// One command is in work at a time; the next word is taken once the
// result sits in the output register, even if the receiver has not yet
// taken it. A stalled receiver holds the result and, after the following
// command finishes, holds off the input. Reset empties every slot and
// closes all scopes; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`include "scoped_symbol_table_core_assert.svh"

module scoped_symbol_table_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_DEPTH   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,  // command[1:0], key[65:2], value[97:66], zero pad
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [39:0]   m_axis_tdata   // status[2:0], found_value[34:3], zero pad
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [sst_pkg::LVL_W-1:0] DEPTH_MAX = sst_pkg::LVL_W'(MAX_DEPTH);

  logic [1:0]                   state_q;
  logic [sst_pkg::LVL_W-1:0]    depth_q;
  sst_pkg::token_t              launch_q;
  logic                         launch_valid_q;
  logic [sst_pkg::ST_W-1:0]     pend_status_q;
  logic [sst_pkg::VAL_W-1:0]    pend_found_q;
  logic                         out_valid_q;
  logic [sst_pkg::ST_W-1:0]     out_status_q;
  logic [sst_pkg::VAL_W-1:0]    out_found_q;

  logic [sst_pkg::CMD_W-1:0]    in_cmd;
  logic [sst_pkg::KEY_W-1:0]    in_key;
  logic [sst_pkg::VAL_W-1:0]    in_value;
  logic                         in_fire;

  sst_pkg::token_t              chain_tok   [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]         chain_valid;
  sst_pkg::token_t              ret_tok;
  logic                         ret_valid;

  assign in_cmd   = s_axis_tdata[1:0];
  assign in_key   = s_axis_tdata[65:2];
  assign in_value = s_axis_tdata[97:66];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign chain_tok[0]   = launch_q;
  assign chain_valid[0] = launch_valid_q;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    sst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (chain_valid[g]),
      .tok_i       (chain_tok[g]),
      .tok_valid_o (chain_valid[g+1]),
      .tok_o       (chain_tok[g+1])
    );
  end

  assign ret_tok   = chain_tok[MAX_ENTRIES];
  assign ret_valid = chain_valid[MAX_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      depth_q        <= '0;
      launch_q       <= '0;
      launch_valid_q <= 1'b0;
      pend_status_q  <= sst_pkg::ST_OK;
      pend_found_q   <= '0;
      out_valid_q    <= 1'b0;
      out_status_q   <= sst_pkg::ST_OK;
      out_found_q    <= '0;
    end else begin
      launch_valid_q <= 1'b0;
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            pend_found_q <= '0;
            if (in_cmd == sst_pkg::CMD_OPEN) begin
              if (depth_q >= DEPTH_MAX) begin
                pend_status_q <= sst_pkg::ST_TOO_DEEP;
              end else begin
                pend_status_q <= sst_pkg::ST_OK;
                depth_q       <= depth_q + 1'b1;
              end
              state_q <= S_DONE;
            end else if (depth_q == '0) begin
              pend_status_q <= sst_pkg::ST_NO_SCOPE;
              state_q       <= S_DONE;
            end else begin
              case (in_cmd)
                sst_pkg::CMD_ASSIGN: launch_q.op <= sst_pkg::OP_FIND;
                sst_pkg::CMD_LOOKUP: launch_q.op <= sst_pkg::OP_LOOKUP;
                default:             launch_q.op <= sst_pkg::OP_CLOSE;
              endcase
              launch_q.key        <= in_key;
              launch_q.value      <= in_value;
              launch_q.level      <= depth_q;
              launch_q.hit        <= 1'b0;
              launch_q.best_level <= '0;
              launch_q.best_value <= '0;
              launch_valid_q      <= 1'b1;
              state_q             <= S_BUSY;
            end
          end
        end
        S_BUSY: begin
          if (ret_valid) begin
            pend_found_q <= '0;
            case (ret_tok.op)
              sst_pkg::OP_FIND: begin
                if (ret_tok.hit) begin
                  pend_status_q <= sst_pkg::ST_OK;
                  state_q       <= S_DONE;
                end else begin
                  launch_q        <= ret_tok;
                  launch_q.op     <= sst_pkg::OP_INSERT;
                  launch_valid_q  <= 1'b1;
                end
              end
              sst_pkg::OP_INSERT: begin
                pend_status_q <= ret_tok.hit ? sst_pkg::ST_OK : sst_pkg::ST_FULL;
                state_q       <= S_DONE;
              end
              sst_pkg::OP_LOOKUP: begin
                if (ret_tok.hit) begin
                  pend_status_q <= sst_pkg::ST_OK;
                  pend_found_q  <= ret_tok.best_value;
                end else begin
                  pend_status_q <= sst_pkg::ST_NOT_FOUND;
                end
                state_q <= S_DONE;
              end
              default: begin
                pend_status_q <= sst_pkg::ST_OK;
                depth_q       <= depth_q - 1'b1;
                state_q       <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= pend_status_q;
            out_found_q  <= pend_found_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_found_q, out_status_q};

  `SST_ASSERT_ALWAYS(a_one_token, $onehot0(chain_valid), "more than one token in the cell chain")
  `SST_ASSERT(a_depth_range, depth_q <= DEPTH_MAX, "scope depth beyond limit")
  `SST_ASSERT(a_token_busy, ret_valid |-> state_q == S_BUSY, "token returned while not busy")
  `SST_ASSERT(a_found_ok, m_axis_tvalid && (out_found_q != '0) |-> out_status_q == sst_pkg::ST_OK,
              "found value reported with a failing status")
  `SST_ASSERT(a_close_pops, ret_valid && (ret_tok.op == sst_pkg::OP_CLOSE) |=>
              depth_q == $past(depth_q) - 1'b1, "close did not pop a scope")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for scoped_symbol_table_core
// Drives open, assign, lookup and close words into the core. A scoreboard
// keeps its own copy of the nested-scope table and predicts one reply per
// word. The stimulus covers commands with no scope open, shadowing across
// levels, lookup misses, nesting beyond the limit and a full slot pool.
// Both streams idle at random, and one long receiver stall backs the core
// up until it stops taking input.
// ----------------------------------------------------------------------------
localparam int NUM_SLOTS   = 64;
localparam int MAX_NEST    = 16;
localparam int TOTAL_WORDS = 1050;
localparam int IDLE_LIMIT  = 4000;

typedef struct packed {
  logic [sst_pkg::ST_W-1:0]  status;
  logic [sst_pkg::VAL_W-1:0] found;
} reply_t;

class symtab_scoreboard;
  int unsigned               depth;
  bit                        in_use[NUM_SLOTS];
  logic [sst_pkg::KEY_W-1:0] slot_key[NUM_SLOTS];
  logic [sst_pkg::VAL_W-1:0] slot_value[NUM_SLOTS];
  logic [sst_pkg::LVL_W-1:0] slot_level[NUM_SLOTS];
  reply_t                    pending_replies[$];
  int                        errors;
  int                        cmd_count[4];
  int                        status_count[5];

  function void note_command(input logic [sst_pkg::CMD_W-1:0] cmd,
                             input logic [sst_pkg::KEY_W-1:0] key,
                             input logic [sst_pkg::VAL_W-1:0] val);
    reply_t r;
    int     hit;
    int     i;
    r.status = sst_pkg::ST_OK;
    r.found  = '0;
    hit      = -1;
    if (cmd == sst_pkg::CMD_OPEN) begin
      if (depth >= MAX_NEST) r.status = sst_pkg::ST_TOO_DEEP;
      else depth++;
    end else if (depth == 0) begin
      r.status = sst_pkg::ST_NO_SCOPE;
    end else if (cmd == sst_pkg::CMD_ASSIGN) begin
      for (i = 0; i < NUM_SLOTS; i++)
        if (in_use[i] && slot_level[i] == depth && slot_key[i] == key) hit = i;
      if (hit >= 0) begin
        slot_value[hit] = val;
      end else begin
        for (i = NUM_SLOTS - 1; i >= 0; i--)
          if (!in_use[i]) hit = i;
        if (hit < 0) begin
          r.status = sst_pkg::ST_FULL;
        end else begin
          in_use[hit]     = 1'b1;
          slot_key[hit]   = key;
          slot_value[hit] = val;
          slot_level[hit] = sst_pkg::LVL_W'(depth);
        end
      end
    end else if (cmd == sst_pkg::CMD_LOOKUP) begin
      for (i = 0; i < NUM_SLOTS; i++)
        if (in_use[i] && slot_key[i] == key && (hit < 0 || slot_level[i] > slot_level[hit]))
          hit = i;
      if (hit >= 0) r.found = slot_value[hit];
      else r.status = sst_pkg::ST_NOT_FOUND;
    end else begin
      for (i = 0; i < NUM_SLOTS; i++)
        if (in_use[i] && slot_level[i] == depth) in_use[i] = 1'b0;
      depth--;
    end
    cmd_count[cmd]++;
    status_count[r.status]++;
    pending_replies.push_back(r);
  endfunction

  function void check_reply(input logic [sst_pkg::ST_W-1:0] st,
                            input logic [sst_pkg::VAL_W-1:0] fv);
    reply_t exp_r;
    if (pending_replies.size() == 0) begin
      $display("%0t: reply with nothing pending: status %0d found %h", $time, st, fv);
      errors++;
      return;
    end
    exp_r = pending_replies.pop_front();
    if (st !== exp_r.status) begin
      $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, st);
      errors++;
    end
    if (fv !== exp_r.found) begin
      $display("%0t: found_value expected %h, actual %h", $time, exp_r.found, fv);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // command[1:0], key[65:2], value[97:66], zero pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;       // status[2:0], found_value[34:3], zero pad

  symtab_scoreboard          sb;
  logic [sst_pkg::KEY_W-1:0] key_pool[10];
  bit                        tx_calm;
  int                        words_sent;
  int                        replies_seen;
  int                        idle_cycles;

  scoped_symbol_table_core #(
    .MAX_ENTRIES(NUM_SLOTS),
    .MAX_DEPTH  (MAX_NEST)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [sst_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 9)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [sst_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input logic [sst_pkg::CMD_W-1:0] cmd,
                          input logic [sst_pkg::KEY_W-1:0] key,
                          input logic [sst_pkg::VAL_W-1:0] val);
    int gap;
    gap = pick_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, key, val);
    words_sent++;
  endtask

  task automatic close_all(input bit extra);
    while (sb.depth > 0) send_cmd(sst_pkg::CMD_CLOSE, pick_key(), pick_value());
    if (extra) send_cmd(sst_pkg::CMD_CLOSE, pick_key(), pick_value());
  endtask

  // Receiver: random ready runs and stalls, plus one long hold-off.
  initial begin
    int  ready_run;
    int  stall_run;
    bit  pressure_done;
    bit  rx_calm;
    ready_run     = 0;
    stall_run     = 0;
    pressure_done = 1'b0;
    rx_calm       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && replies_seen >= 300) begin
        pressure_done = 1'b1;
        stall_run     = 700;
        ready_run     = 0;
      end
      if (stall_run > 0) begin
        m_axis_tready <= 1'b0;
        stall_run--;
      end else begin
        m_axis_tready <= 1'b1;
        if (ready_run > 0) begin
          ready_run--;
        end else begin
          if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
          ready_run = $urandom_range(0, 24);
          stall_run = pick_gap(rx_calm);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_reply(m_axis_tdata[2:0], m_axis_tdata[34:3]);
      replies_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int                        r;
    int                        n;
    int                        i;
    logic [sst_pkg::CMD_W-1:0] cmd;
    logic [sst_pkg::KEY_W-1:0] fresh_key;
    sb          = new;
    tx_calm     = 1'b0;
    words_sent  = 0;
    key_pool[0] = "i";
    key_pool[1] = "count";
    key_pool[2] = "tmp";
    key_pool[3] = "sum";
    key_pool[4] = "abcdefgh";
    key_pool[5] = "x";
    key_pool[6] = '0;
    key_pool[7] = '1;
    key_pool[8] = {$urandom, $urandom};
    key_pool[9] = {$urandom, $urandom};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no scope open
    send_cmd(sst_pkg::CMD_LOOKUP, "i", 32'h1);
    send_cmd(sst_pkg::CMD_ASSIGN, "i", 32'h1);
    send_cmd(sst_pkg::CMD_CLOSE, '0, '0);
    // insert, update, hit and miss at one level
    send_cmd(sst_pkg::CMD_OPEN, '1, '1);
    send_cmd(sst_pkg::CMD_ASSIGN, '0, 32'h8000_0000);
    send_cmd(sst_pkg::CMD_ASSIGN, '1, 32'h7FFF_FFFF);
    send_cmd(sst_pkg::CMD_ASSIGN, '0, 32'hFFFF_FFFF);
    send_cmd(sst_pkg::CMD_LOOKUP, '0, '0);
    send_cmd(sst_pkg::CMD_LOOKUP, '1, '0);
    send_cmd(sst_pkg::CMD_LOOKUP, "zz", '0);
    // shadow in an inner scope, then drop it
    send_cmd(sst_pkg::CMD_OPEN, '0, '0);
    send_cmd(sst_pkg::CMD_ASSIGN, '0, 32'h0000_0005);
    send_cmd(sst_pkg::CMD_LOOKUP, '0, '0);
    send_cmd(sst_pkg::CMD_LOOKUP, '1, '0);
    send_cmd(sst_pkg::CMD_CLOSE, '1, '1);
    send_cmd(sst_pkg::CMD_LOOKUP, '0, '0);
    send_cmd(sst_pkg::CMD_CLOSE, '0, '0);
    send_cmd(sst_pkg::CMD_LOOKUP, '0, '0);

    while (words_sent < TOTAL_WORDS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // nest past the limit, work a little, unwind fully
        n = MAX_NEST - int'(sb.depth) + $urandom_range(1, 2);
        repeat (n) send_cmd(sst_pkg::CMD_OPEN, pick_key(), pick_value());
        repeat (6) begin
          cmd = ($urandom_range(0, 1) == 0) ? sst_pkg::CMD_ASSIGN : sst_pkg::CMD_LOOKUP;
          send_cmd(cmd, pick_key(), pick_value());
        end
        close_all(1'b1);
      end else if (r < 13) begin
        // exhaust the slot pool
        if (sb.depth == 0) send_cmd(sst_pkg::CMD_OPEN, pick_key(), pick_value());
        n = $urandom_range(1, 3);
        for (i = 0; i < NUM_SLOTS; i++)
          if (!sb.in_use[i]) n++;
        fresh_key = {$urandom, $urandom};
        send_cmd(sst_pkg::CMD_ASSIGN, fresh_key, pick_value());
        repeat (n - 1) send_cmd(sst_pkg::CMD_ASSIGN, {$urandom, $urandom}, pick_value());
        send_cmd(sst_pkg::CMD_ASSIGN, fresh_key, pick_value());
        send_cmd(sst_pkg::CMD_LOOKUP, fresh_key, '0);
        repeat (3) send_cmd(sst_pkg::CMD_LOOKUP, pick_key(), '0);
        if ($urandom_range(0, 1) == 0) close_all(1'b0);
      end else begin
        repeat (20) begin
          r = $urandom_range(0, 99);
          if (sb.depth == 0) begin
            cmd = (r < 85) ? sst_pkg::CMD_OPEN : sst_pkg::CMD_W'($urandom_range(1, 3));
          end else begin
            if (r < 14) cmd = sst_pkg::CMD_OPEN;
            else if (r < 50) cmd = sst_pkg::CMD_ASSIGN;
            else if (r < 85) cmd = sst_pkg::CMD_LOOKUP;
            else cmd = sst_pkg::CMD_CLOSE;
          end
          send_cmd(cmd, pick_key(), pick_value());
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_SLOTS + 16) @(posedge clk_i);

    $display("Covered %0d words: open %0d, assign %0d, lookup %0d, close %0d",
             words_sent, sb.cmd_count[sst_pkg::CMD_OPEN], sb.cmd_count[sst_pkg::CMD_ASSIGN],
             sb.cmd_count[sst_pkg::CMD_LOOKUP], sb.cmd_count[sst_pkg::CMD_CLOSE]);
    $display("Replies: ok %0d, no scope %0d, not found %0d, full %0d, too deep %0d",
             sb.status_count[sst_pkg::ST_OK], sb.status_count[sst_pkg::ST_NO_SCOPE],
             sb.status_count[sst_pkg::ST_NOT_FOUND], sb.status_count[sst_pkg::ST_FULL],
             sb.status_count[sst_pkg::ST_TOO_DEEP]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sst_pkg.sv
sv/sst_cell.sv
sv/scoped_symbol_table_core.sv
sim/tb_top.sv
